// ----- rtl/pose_fan_goal_generator_assert.svh -----
// ----------------------------------------------------------------------------
// Pose fan goal generator assertion macros
// Concurrent assertion helpers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef POSE_FAN_GOAL_GENERATOR_ASSERT_SVH
`define POSE_FAN_GOAL_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define PFG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pose fan goal generator: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define PFG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pose fan goal generator: next-cycle check failed");

`else

`define PFG_ASSERT_NOW(lbl, ante, cons)
`define PFG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/pfg_pkg.sv -----
// ----------------------------------------------------------------------------
// Pose fan goal generator package
// Shared widths, constants, types and the fan sequence table.
// ----------------------------------------------------------------------------
package pfg_pkg;

    // Field widths
    localparam int unsigned POS_W   = 32;
    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned STEP_W  = 24;
    localparam int unsigned GAIN_W  = 5;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned MAG_W   = 26;
    localparam int unsigned SINE_W  = 17;
    localparam int unsigned CFG_IDX_W = 2;

    // Trig pipeline
    localparam logic [30:0] HALF_PI_Q30   = 31'd1686629713;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [ANGLE_W-1:0] HALF_TURN    = 16'h8000;
    localparam int unsigned SERIES_TERMS  = 7;
    // input, radians, square, three per series term, round, multiply, round
    localparam int unsigned PIPE_DEPTH    = 3 + 3 * SERIES_TERMS + 3;

    // Run layout
    localparam logic [IDX_W-1:0]  LAST_PLAIN = 4'd8;
    localparam logic [IDX_W-1:0]  LAST_REV   = 4'd9;
    localparam logic [GAIN_W-1:0] REV_GAIN   = 5'd17;

    // Register reset values
    localparam logic [STEP_W-1:0]  STEP_RESET  = 24'd65536;
    localparam logic [ANGLE_W-1:0] ANGLE_RESET = 16'd1820;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_DISTANCE = 2'd0,
        CFG_ANGLE_STEP    = 2'd1,
        CFG_ALLOW_REVERSE = 2'd2
    } cfg_index_t;

    // Heading change of one fan entry
    typedef enum logic [1:0] {
        TURN_NONE,
        TURN_POS,
        TURN_NEG,
        TURN_HALF
    } turn_t;

    typedef struct packed {
        logic [1:0]        steps_mag;
        logic              steps_neg;
        turn_t             turn;
        logic [GAIN_W-1:0] gain;
    } fan_entry_t;

    // Side offsets of one axis: sign and rounded magnitudes for one and two steps
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag1;
        logic [MAG_W-1:0] mag2;
    } axis_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [ANGLE_W-1:0]      heading;
    } pose_t;

    localparam logic signed [POS_W+1:0] WIDE_MAX = 34'sd2147483647;
    localparam logic signed [POS_W+1:0] WIDE_MIN = -34'sd2147483648;

    // Fan sequence, in run order
    function automatic fan_entry_t fan_entry(logic [IDX_W-1:0] idx);
        fan_entry_t e;
        case (idx)
            4'd0:    e = '{2'd0, 1'b0, TURN_NONE, 5'd10};
            4'd1:    e = '{2'd1, 1'b0, TURN_NONE, 5'd10};
            4'd2:    e = '{2'd1, 1'b0, TURN_POS,  5'd11};
            4'd3:    e = '{2'd1, 1'b1, TURN_NONE, 5'd10};
            4'd4:    e = '{2'd1, 1'b1, TURN_NEG,  5'd11};
            4'd5:    e = '{2'd2, 1'b0, TURN_NONE, 5'd12};
            4'd6:    e = '{2'd2, 1'b0, TURN_POS,  5'd12};
            4'd7:    e = '{2'd2, 1'b1, TURN_NONE, 5'd12};
            4'd8:    e = '{2'd2, 1'b1, TURN_NEG,  5'd12};
            4'd9:    e = '{2'd0, 1'b0, TURN_HALF, REV_GAIN};
            default: e = '{2'd0, 1'b0, TURN_NONE, 5'd10};
        endcase
        return e;
    endfunction

    // Center coordinate plus signed offset, saturated to 32 bits
    function automatic logic signed [POS_W-1:0] sat_offset(
        logic signed [POS_W-1:0] base,
        logic [MAG_W-1:0]        mag,
        logic                    neg
    );
        logic signed [POS_W+1:0] off;
        logic signed [POS_W+1:0] sum;
        logic signed [POS_W-1:0] res;
        off = signed'({8'd0, mag});
        if (neg)
        begin
            off = -off;
        end
        sum = (POS_W + 2)'(base) + off;
        if (sum > WIDE_MAX)
        begin
            res = WIDE_MAX[POS_W-1:0];
        end
        else if (sum < WIDE_MIN)
        begin
            res = WIDE_MIN[POS_W-1:0];
        end
        else
        begin
            res = sum[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/pfg_center_if.sv -----
// ----------------------------------------------------------------------------
// Center pose channel
// Valid/ready channel carrying one center pose per item.
// ----------------------------------------------------------------------------
interface pfg_center_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pfg_pkg::POS_W-1:0]      center_x;
    logic signed [pfg_pkg::POS_W-1:0]      center_y;
    logic [pfg_pkg::ANGLE_W-1:0]           center_heading;

    modport source (output valid, output center_x, output center_y,
                    output center_heading, input ready);
    modport sink   (input valid, input center_x, input center_y,
                    input center_heading, output ready);
endinterface

// ----- rtl/pfg_goal_if.sv -----
// ----------------------------------------------------------------------------
// Goal pose channel
// Valid/ready channel carrying one goal pose with its gain per item.
// ----------------------------------------------------------------------------
interface pfg_goal_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pfg_pkg::POS_W-1:0]      goal_x;
    logic signed [pfg_pkg::POS_W-1:0]      goal_y;
    logic [pfg_pkg::ANGLE_W-1:0]           goal_heading;
    logic [pfg_pkg::GAIN_W-1:0]            gain_tenths;
    logic                                  last_goal;

    modport source (output valid, output goal_x, output goal_y, output goal_heading,
                    output gain_tenths, output last_goal, input ready);
    modport sink   (input valid, input goal_x, input goal_y, input goal_heading,
                    input gain_tenths, input last_goal, output ready);
endinterface

// ----- rtl/pfg_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready register write: register index and write data.
// ----------------------------------------------------------------------------
interface pfg_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [pfg_pkg::CFG_IDX_W-1:0]         index;
    logic [pfg_pkg::STEP_W-1:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/pfg_axis_pipe.sv -----
// ----------------------------------------------------------------------------
// Side offset pipeline for one axis
// Sine of a binary angle by a Q30 odd series, one stage group per term,
// then the one- and two-step offsets, rounded half away from zero.
// ----------------------------------------------------------------------------
module pfg_axis_pipe (
    input  logic                              clk,
    input  logic                              adv,
    input  logic [pfg_pkg::ANGLE_W-1:0]       angle,
    input  logic [pfg_pkg::STEP_W-1:0]        step_distance,
    output pfg_pkg::axis_t                    axis
);

    localparam int unsigned NT = pfg_pkg::SERIES_TERMS;

    // Stage 0: quadrant reduction
    logic [14:0] s0_r_reg;
    logic        s0_neg_reg;
    logic [14:0] s0_r_next;

    always_comb
    begin
        if (angle[14])
        begin
            s0_r_next = 15'h4000 - {1'b0, angle[13:0]};
        end
        else
        begin
            s0_r_next = {1'b0, angle[13:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_r_reg   <= s0_r_next;
            s0_neg_reg <= angle[15];
        end
    end

    // Stage 1: angle to Q30 radians
    logic [30:0] s1_x_reg;
    logic        s1_neg_reg;
    logic [45:0] s1_prod;

    assign s1_prod = 46'(s0_r_reg) * 46'(pfg_pkg::HALF_PI_Q30) + 46'd8192;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg   <= s1_prod[44:14];
            s1_neg_reg <= s0_neg_reg;
        end
    end

    // Stage 2: square, series seeded with x
    logic [31:0]        s2_term_reg;
    logic [31:0]        s2_x2_reg;
    logic signed [33:0] s2_sum_reg;
    logic               s2_neg_reg;
    logic [61:0]        s2_prod;

    assign s2_prod = 62'(s1_x_reg) * 62'(s1_x_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_term_reg <= {1'b0, s1_x_reg};
            s2_x2_reg   <= s2_prod[61:30];
            s2_sum_reg  <= signed'({3'd0, s1_x_reg});
            s2_neg_reg  <= s1_neg_reg;
        end
    end

    // Links between series terms
    logic [31:0]        term_w [NT+1];
    logic [31:0]        x2_w   [NT+1];
    logic signed [33:0] sum_w  [NT+1];
    logic               neg_w  [NT+1];

    assign term_w[0] = s2_term_reg;
    assign x2_w[0]   = s2_x2_reg;
    assign sum_w[0]  = s2_sum_reg;
    assign neg_w[0]  = s2_neg_reg;

    // One group of three stages per series term
    for (genvar gi = 0; gi < NT; gi++)
    begin : g_term
        localparam int unsigned DIV    = (2 * (gi + 1)) * (2 * (gi + 1) + 1);
        localparam logic [29:0] RECIP  = 30'((64'd1 << 32) / DIV);
        localparam bit          SUBTR  = (gi % 2) == 0;

        logic [31:0]        a_v_reg;
        logic [31:0]        a_x2_reg;
        logic signed [33:0] a_sum_reg;
        logic               a_neg_reg;
        logic [63:0]        a_prod;

        logic [29:0]        b_q_reg;
        logic [31:0]        b_v_reg;
        logic [31:0]        b_x2_reg;
        logic signed [33:0] b_sum_reg;
        logic               b_neg_reg;
        logic [61:0]        b_prod;

        logic [31:0]        c_term_reg;
        logic [31:0]        c_x2_reg;
        logic signed [33:0] c_sum_reg;
        logic               c_neg_reg;
        logic [37:0]        c_back;
        logic [31:0]        c_rem;
        logic [31:0]        c_term_next;
        logic signed [33:0] c_sum_next;

        // term * x^2 in Q30
        assign a_prod = 64'(term_w[gi]) * 64'(x2_w[gi]);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a_v_reg   <= a_prod[61:30];
                a_x2_reg  <= x2_w[gi];
                a_sum_reg <= sum_w[gi];
                a_neg_reg <= neg_w[gi];
            end
        end

        // Quotient estimate by reciprocal, low by at most one
        assign b_prod = 62'(a_v_reg) * 62'(RECIP);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                b_q_reg   <= b_prod[61:32];
                b_v_reg   <= a_v_reg;
                b_x2_reg  <= a_x2_reg;
                b_sum_reg <= a_sum_reg;
                b_neg_reg <= a_neg_reg;
            end
        end

        // Remainder correction and accumulate with alternating sign
        always_comb
        begin
            c_back = 38'(b_q_reg) * 38'(DIV);
            c_rem  = b_v_reg - c_back[31:0];
            if (c_rem >= 32'(DIV))
            begin
                c_term_next = 32'(b_q_reg) + 32'd1;
            end
            else
            begin
                c_term_next = 32'(b_q_reg);
            end
            if (SUBTR)
            begin
                c_sum_next = b_sum_reg - signed'({2'd0, c_term_next});
            end
            else
            begin
                c_sum_next = b_sum_reg + signed'({2'd0, c_term_next});
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                c_term_reg <= c_term_next;
                c_x2_reg   <= b_x2_reg;
                c_sum_reg  <= c_sum_next;
                c_neg_reg  <= b_neg_reg;
            end
        end

        assign term_w[gi+1] = c_term_reg;
        assign x2_w[gi+1]   = c_x2_reg;
        assign sum_w[gi+1]  = c_sum_reg;
        assign neg_w[gi+1]  = c_neg_reg;
    end

    // Round to Q16 and clamp to [0, 1.0]
    logic [pfg_pkg::SINE_W-1:0] f_q_reg;
    logic                       f_neg_reg;
    logic [33:0]                f_pos;
    logic [33:0]                f_rnd;
    logic [pfg_pkg::SINE_W-1:0] f_q_next;

    always_comb
    begin
        if (sum_w[NT] < 0)
        begin
            f_pos = '0;
        end
        else
        begin
            f_pos = unsigned'(sum_w[NT]);
        end
        f_rnd = f_pos + 34'd8192;
        if (f_rnd[33:14] > 20'd65536)
        begin
            f_q_next = 17'd65536;
        end
        else
        begin
            f_q_next = f_rnd[30:14];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_q_reg   <= f_q_next;
            f_neg_reg <= neg_w[NT];
        end
    end

    // Step times sine
    logic [40:0] m_prod_reg;
    logic        m_neg_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_prod_reg <= 41'(step_distance) * 41'(f_q_reg);
            m_neg_reg  <= f_neg_reg;
        end
    end

    // Rounded magnitudes for one and two steps
    logic [41:0] r_one;
    logic [42:0] r_two;
    pfg_pkg::axis_t axis_reg;

    assign r_one = 42'(m_prod_reg) + 42'd32768;
    assign r_two = {1'b0, m_prod_reg, 1'b0} + 43'd32768;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            axis_reg.neg  <= m_neg_reg;
            axis_reg.mag1 <= r_one[41:16];
            axis_reg.mag2 <= r_two[41:16];
        end
    end

    assign axis = axis_reg;

endmodule

// ----- rtl/pose_fan_goal_generator.sv -----
// ----------------------------------------------------------------------------
// Pose fan goal generator
// Expands one center pose into a run of side-shifted and turned goal poses.
// ----------------------------------------------------------------------------
// Path: a center passes 27 pipeline registers (counting the one that takes it), the
// emitter load and the output register before its first goal is valid.
// Throughput: one goal per cycle while the goal port is ready; a center yields a run
// of 9 goals, 10 with reverse enabled, and the next center loads with the last goal.
// Reset: pipeline and emitter empty, registers at step 1.0 m, angle 1820, no reverse.
`include "pose_fan_goal_generator_assert.svh"

module pose_fan_goal_generator (
    input  logic              clk,
    input  logic              rst_n,
    pfg_center_if.sink        center,
    pfg_goal_if.source        goal,
    pfg_cfg_if.sink           cfg
);

    localparam int unsigned LAST_TAP = pfg_pkg::PIPE_DEPTH - 1;

    // Configuration registers
    logic [pfg_pkg::STEP_W-1:0]  step_distance_reg;
    logic [pfg_pkg::ANGLE_W-1:0] angle_step_reg;
    logic                        allow_reverse_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_distance_reg <= pfg_pkg::STEP_RESET;
            angle_step_reg    <= pfg_pkg::ANGLE_RESET;
            allow_reverse_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                pfg_pkg::CFG_STEP_DISTANCE: step_distance_reg <= cfg.data;
                pfg_pkg::CFG_ANGLE_STEP:    angle_step_reg    <= cfg.data[pfg_pkg::ANGLE_W-1:0];
                pfg_pkg::CFG_ALLOW_REVERSE: allow_reverse_reg <= cfg.data[0];
                default:                    ;
            endcase
        end
    end

    // Pipeline advance: moves whenever the end stage is empty or the emitter is free
    // or finishing its run in this cycle
    logic busy_reg;
    logic [pfg_pkg::IDX_W-1:0] idx_reg;
    logic out_valid_reg;
    logic fire;
    logic at_last;
    logic run_done;
    logic vld_reg [pfg_pkg::PIPE_DEPTH];
    logic adv;
    logic load;

    assign run_done     = fire && at_last;
    assign adv          = !vld_reg[LAST_TAP] || !busy_reg || run_done;
    assign load         = vld_reg[LAST_TAP] && (!busy_reg || run_done);
    assign center.ready = adv;

    // Center pose delay line, aligned with the axis pipelines
    pfg_pkg::pose_t pose_reg [pfg_pkg::PIPE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pfg_pkg::PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= center.valid;
            for (int i = 1; i < pfg_pkg::PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pose_reg[0] <= '{center.center_x, center.center_y, center.center_heading};
            for (int i = 1; i < pfg_pkg::PIPE_DEPTH; i++)
            begin
                pose_reg[i] <= pose_reg[i-1];
            end
        end
    end

    // Side vector is (-sin h, cos h); cos h = sin(h + quarter turn)
    pfg_pkg::axis_t axis_x;
    pfg_pkg::axis_t axis_y;
    logic [pfg_pkg::ANGLE_W-1:0] cos_angle;

    assign cos_angle = center.center_heading + pfg_pkg::QUARTER_TURN;

    pfg_axis_pipe u_axis_x (
        .clk           (clk),
        .adv           (adv),
        .angle         (center.center_heading),
        .step_distance (step_distance_reg),
        .axis          (axis_x)
    );

    pfg_axis_pipe u_axis_y (
        .clk           (clk),
        .adv           (adv),
        .angle         (cos_angle),
        .step_distance (step_distance_reg),
        .axis          (axis_y)
    );

    // Emitter: holds one center and walks the fan
    pfg_pkg::pose_t            item_reg;
    pfg_pkg::axis_t            item_x_reg;
    pfg_pkg::axis_t            item_y_reg;

    assign fire    = busy_reg && (!out_valid_reg || goal.ready);
    assign at_last = (idx_reg == pfg_pkg::LAST_REV) ||
                     ((idx_reg == pfg_pkg::LAST_PLAIN) && !allow_reverse_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (fire)
        begin
            if (at_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    // x side component is -sin h, so its sign flips
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg        <= pose_reg[LAST_TAP];
            item_x_reg.neg  <= !axis_x.neg;
            item_x_reg.mag1 <= axis_x.mag1;
            item_x_reg.mag2 <= axis_x.mag2;
            item_y_reg      <= axis_y;
        end
    end

    // Goal of the current fan entry
    pfg_pkg::fan_entry_t         entry;
    logic [pfg_pkg::MAG_W-1:0]   mag_x;
    logic [pfg_pkg::MAG_W-1:0]   mag_y;
    logic signed [pfg_pkg::POS_W-1:0] goal_x_next;
    logic signed [pfg_pkg::POS_W-1:0] goal_y_next;
    logic [pfg_pkg::ANGLE_W-1:0] goal_heading_next;

    always_comb
    begin
        entry = pfg_pkg::fan_entry(idx_reg);
        case (entry.steps_mag)
            2'd1:
            begin
                mag_x = item_x_reg.mag1;
                mag_y = item_y_reg.mag1;
            end
            2'd2:
            begin
                mag_x = item_x_reg.mag2;
                mag_y = item_y_reg.mag2;
            end
            default:
            begin
                mag_x = '0;
                mag_y = '0;
            end
        endcase
        goal_x_next = pfg_pkg::sat_offset(item_reg.x, mag_x, item_x_reg.neg ^ entry.steps_neg);
        goal_y_next = pfg_pkg::sat_offset(item_reg.y, mag_y, item_y_reg.neg ^ entry.steps_neg);
        case (entry.turn)
            pfg_pkg::TURN_POS:  goal_heading_next = item_reg.heading + angle_step_reg;
            pfg_pkg::TURN_NEG:  goal_heading_next = item_reg.heading - angle_step_reg;
            pfg_pkg::TURN_HALF: goal_heading_next = item_reg.heading + pfg_pkg::HALF_TURN;
            default:            goal_heading_next = item_reg.heading;
        endcase
    end

    // Output register
    logic signed [pfg_pkg::POS_W-1:0] goal_x_reg;
    logic signed [pfg_pkg::POS_W-1:0] goal_y_reg;
    logic [pfg_pkg::ANGLE_W-1:0]      goal_heading_reg;
    logic [pfg_pkg::GAIN_W-1:0]       gain_tenths_reg;
    logic                             last_goal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (goal.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            goal_x_reg       <= goal_x_next;
            goal_y_reg       <= goal_y_next;
            goal_heading_reg <= goal_heading_next;
            gain_tenths_reg  <= entry.gain;
            last_goal_reg    <= at_last;
        end
    end

    assign goal.valid        = out_valid_reg;
    assign goal.goal_x       = goal_x_reg;
    assign goal.goal_y       = goal_y_reg;
    assign goal.goal_heading = goal_heading_reg;
    assign goal.gain_tenths  = gain_tenths_reg;
    assign goal.last_goal    = last_goal_reg;

    // Checks
    `PFG_ASSERT_NEXT(a_load_starts_run, load, busy_reg && (idx_reg == '0))
    `PFG_ASSERT_NOW(a_idx_in_range, busy_reg, idx_reg <= pfg_pkg::LAST_REV)
    `PFG_ASSERT_NEXT(a_run_ends_on_last, fire && at_last, goal.valid && goal.last_goal)
    `PFG_ASSERT_NOW(a_reverse_is_last, goal.valid && (goal.gain_tenths == pfg_pkg::REV_GAIN), goal.last_goal)

endmodule
